[src/ilid_pkg.sv]
`default_nettype none
package ilid_pkg;

  localparam int CAPACITY = 64;
  localparam int POS_W    = $clog2(CAPACITY);
  localparam int IDX_W    = 6;
  localparam int CNT_W    = 7;
  localparam int DATA_W   = 32;
  localparam int CMD_W    = 3;
  localparam int STAT_W   = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND  = 3'd0,
    CMD_INSERT  = 3'd1,
    CMD_EDIT    = 3'd2,
    CMD_DELETE  = 3'd3,
    CMD_DISPLAY = 3'd4,
    CMD_CLEAR   = 3'd5
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2,
    STAT_EMPTY = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CELL_HOLD   = 3'd0,
    CELL_WRITE  = 3'd1,
    CELL_INSERT = 3'd2,
    CELL_DELETE = 3'd3,
    CELL_ROTATE = 3'd4
  } cell_op_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_DISP = 1'b1
  } state_t;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    cell_op_t          op;
    logic [IDX_W-1:0]  idx;
    logic [CNT_W-1:0]  count;
    logic [DATA_W-1:0] value;
  } cell_ctrl_t;

endpackage
`default_nettype wire

[src/ilid_cell.sv]
`default_nettype none
module ilid_cell import ilid_pkg::*; (
  input  wire logic              clk,
  input  wire cell_ctrl_t        ctrl,
  input  wire logic [IDX_W-1:0]  slot,
  input  wire logic [DATA_W-1:0] left,
  input  wire logic [DATA_W-1:0] right,
  input  wire logic [DATA_W-1:0] wrap,
  output logic      [DATA_W-1:0] data
);

  logic [CNT_W-1:0]  slot_ext;
  logic [CNT_W-1:0]  idx_ext;
  logic [DATA_W-1:0] data_next;

  assign slot_ext = {1'b0, slot};
  assign idx_ext  = {1'b0, ctrl.idx};

  always_comb begin
    data_next = data;
    case (ctrl.op)
      CELL_WRITE: begin
        if (slot_ext == idx_ext) data_next = ctrl.value;
      end
      CELL_INSERT: begin
        if (slot_ext == idx_ext) data_next = ctrl.value;
        else if (slot_ext > idx_ext) data_next = left;
      end
      CELL_DELETE: begin
        if (slot_ext >= idx_ext) data_next = right;
      end
      CELL_ROTATE: begin
        // The occupied part of the row turns by one place toward cell zero.
        if (slot_ext + CNT_W'(1) == ctrl.count) data_next = wrap;
        else if (slot_ext < ctrl.count) data_next = right;
      end
      default: data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule
`default_nettype wire

[src/ilid_chain.sv]
`default_nettype none
module ilid_chain import ilid_pkg::*; (
  input  wire logic              clk,
  input  wire cell_ctrl_t        ctrl,
  output logic      [DATA_W-1:0] sel_data,
  output logic      [DATA_W-1:0] head_data
);

  logic [DATA_W-1:0] cell_data [CAPACITY];
  logic [DATA_W-1:0] left_in   [CAPACITY];
  logic [DATA_W-1:0] right_in  [CAPACITY];

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign left_in[g] = '0;
    end else begin : g_mid_l
      assign left_in[g] = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_in[g] = '0;
    end else begin : g_mid_r
      assign right_in[g] = cell_data[g+1];
    end

    ilid_cell u_cell (
      .clk   (clk),
      .ctrl  (ctrl),
      .slot  (IDX_W'(g)),
      .left  (left_in[g]),
      .right (right_in[g]),
      .wrap  (cell_data[0]),
      .data  (cell_data[g])
    );
  end

  // Read of the addressed entry, used only when the index was checked.
  assign sel_data  = cell_data[ctrl.idx[POS_W-1:0]];
  assign head_data = cell_data[0];

endmodule
`default_nettype wire

[src/indexed_list_insert_delete_core.sv]
`default_nettype none
// Channel  Dir  Handshake                  Payload
// s_axis   in   s_axis_tvalid/tready       tdata: command, value, index
// m_axis   out  m_axis_tvalid/tready       tdata: value_res, position, count;
//                                          tuser: status; tlast: last
//
// Append, insert, edit, delete, clear and unused codes are done in the accepting
// cycle: the whole row of cells shifts or writes in parallel in that cycle.
// Display of a non-empty list starts in the accepting cycle and then gives one
// result per entry, and an empty list gives a single result; the row rotates by
// one place with each result loaded, so that cell zero always holds the next
// entry, and it is back in order after the last one.
// Reset clears the entry count, the control state and the output valid; the
// entries themselves are not cleared and are never read before being written.
// A stalled output holds its result and blocks the input; a result that is
// taken frees the output register in the same cycle, so commands can follow
// back to back.
module indexed_list_insert_delete_core import ilid_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,   // command[2:0], value[34:3], index[40:35], zeros
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [47:0] m_axis_tdata,   // value_res[31:0], position[37:32], count[44:38], zeros
  output logic      [1:0]  m_axis_tuser,   // status[1:0]
  output logic             m_axis_tlast
);

  // Input fields.
  cmd_t              in_cmd;
  logic [DATA_W-1:0] in_value;
  logic [IDX_W-1:0]  in_index;

  assign in_cmd   = cmd_t'(s_axis_tdata[2:0]);
  assign in_value = s_axis_tdata[34:3];
  assign in_index = s_axis_tdata[40:35];

  // Control and list state.
  state_t           state, state_next;
  logic [CNT_W-1:0] entry_count, entry_count_next;
  logic [IDX_W-1:0] disp_ptr, disp_ptr_next;

  // Output register.
  logic              out_valid, out_valid_next;
  status_t           out_status, out_status_next;
  logic [DATA_W-1:0] out_value, out_value_next;
  logic [IDX_W-1:0]  out_pos, out_pos_next;
  logic [CNT_W-1:0]  out_count, out_count_next;
  logic              out_last, out_last_next;

  cell_ctrl_t        ctrl;
  logic [DATA_W-1:0] sel_data;
  logic [DATA_W-1:0] head_data;
  logic              out_free;
  logic              in_fire;
  logic              load;
  logic [CNT_W-1:0]  idx_ext;
  logic              is_full;

  assign out_free      = !out_valid || m_axis_tready;
  assign s_axis_tready = (state == ST_IDLE) && out_free;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign idx_ext       = {1'b0, in_index};
  assign is_full       = entry_count >= CNT_W'(CAPACITY);

  ilid_chain u_chain (
    .clk       (clk),
    .ctrl      (ctrl),
    .sel_data  (sel_data),
    .head_data (head_data)
  );

  always_comb begin
    state_next       = state;
    entry_count_next = entry_count;
    disp_ptr_next    = disp_ptr;
    ctrl.op          = CELL_HOLD;
    ctrl.idx         = in_index;
    ctrl.count       = entry_count;
    ctrl.value       = in_value;
    load             = 1'b0;
    out_status_next  = STAT_OK;
    out_value_next   = '0;
    out_pos_next     = '0;
    out_count_next   = entry_count;
    out_last_next    = 1'b1;

    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          load = 1'b1;
          case (in_cmd)
            CMD_APPEND: begin
              if (is_full) begin
                out_status_next = STAT_FULL;
              end else begin
                ctrl.op          = CELL_WRITE;
                ctrl.idx         = entry_count[IDX_W-1:0];
                entry_count_next = entry_count + CNT_W'(1);
                out_value_next   = in_value;
                out_pos_next     = entry_count[IDX_W-1:0];
                out_count_next   = entry_count + CNT_W'(1);
              end
            end
            CMD_INSERT: begin
              out_pos_next = in_index;
              if (is_full) begin
                out_status_next = STAT_FULL;
              end else if (idx_ext > entry_count) begin
                out_status_next = STAT_RANGE;
              end else begin
                ctrl.op          = CELL_INSERT;
                entry_count_next = entry_count + CNT_W'(1);
                out_value_next   = in_value;
                out_count_next   = entry_count + CNT_W'(1);
              end
            end
            CMD_EDIT: begin
              out_pos_next = in_index;
              if (entry_count == '0) begin
                out_status_next = STAT_EMPTY;
              end else if (idx_ext >= entry_count) begin
                out_status_next = STAT_RANGE;
              end else begin
                ctrl.op        = CELL_WRITE;
                out_value_next = in_value;
              end
            end
            CMD_DELETE: begin
              out_pos_next = in_index;
              if (entry_count == '0) begin
                out_status_next = STAT_EMPTY;
              end else if (idx_ext >= entry_count) begin
                out_status_next = STAT_RANGE;
              end else begin
                ctrl.op          = CELL_DELETE;
                entry_count_next = entry_count - CNT_W'(1);
                out_value_next   = sel_data;
                out_count_next   = entry_count - CNT_W'(1);
              end
            end
            CMD_DISPLAY: begin
              if (entry_count == '0) begin
                out_status_next = STAT_EMPTY;
              end else begin
                // Results come from the streaming state, one per entry.
                load          = 1'b0;
                disp_ptr_next = '0;
                state_next    = ST_DISP;
              end
            end
            CMD_CLEAR: begin
              entry_count_next = '0;
              out_count_next   = '0;
            end
            default: begin
              // Unused command codes answer with a plain ok result.
            end
          endcase
        end
      end
      ST_DISP: begin
        if (out_free) begin
          load           = 1'b1;
          ctrl.op        = CELL_ROTATE;
          out_value_next = head_data;
          out_pos_next   = disp_ptr;
          out_last_next  = ({1'b0, disp_ptr} + CNT_W'(1)) == entry_count;
          disp_ptr_next  = disp_ptr + IDX_W'(1);
          if (out_last_next) state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase

    if (load) out_valid_next = 1'b1;
    else if (m_axis_tready) out_valid_next = 1'b0;
    else out_valid_next = out_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      entry_count <= '0;
      disp_ptr    <= '0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      entry_count <= entry_count_next;
      disp_ptr    <= disp_ptr_next;
      out_valid   <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_status <= out_status_next;
      out_value  <= out_value_next;
      out_pos    <= out_pos_next;
      out_count  <= out_count_next;
      out_last   <= out_last_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {3'b000, out_count, out_pos, out_value};
  assign m_axis_tuser  = out_status;
  assign m_axis_tlast  = out_last;

  // The list never grows beyond its capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(CAPACITY))
    else $error("entry count exceeds capacity");

  // While streaming, the read pointer stays inside the occupied part.
  a_disp_ptr: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DISP) |-> ({1'b0, disp_ptr} < entry_count))
    else $error("display pointer past the end of the list");

  // Every command other than display answers in the next cycle.
  a_single_result: assert property (@(posedge clk) disable iff (rst)
    (in_fire && in_cmd != CMD_DISPLAY) |=> (m_axis_tvalid && m_axis_tlast))
    else $error("missing single result after a command");

endmodule
`default_nettype wire
